// ===== design/plfe_pkg.sv =====
// Shared types and constants of the supply link frame engine.
// Used by every module of the block; depends on nothing.
package plfe_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned MaxCh    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ACTIVE_CH = 3'd0,
    REG_VSET      = 3'd1,
    REG_ILIM      = 3'd2,
    REG_EN_REQ    = 3'd3,
    REG_OCP_REQ   = 3'd4,
    REG_MODE_REQ  = 3'd5,
    REG_ACQ_RUN   = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_TX     = 1'b1
  } kind_e;

  // Byte positions shared by the received and the setting frame
  localparam int unsigned PosChBase = 2;
  localparam int unsigned PosMarkA  = 14;
  localparam int unsigned PosEn     = 15;
  localparam int unsigned PosMarkB  = 16;
  localparam int unsigned PosOcp    = 18;
  localparam int unsigned PosMode   = 19;

  localparam logic [7:0] HdrByte0 = 8'haa;
  localparam logic [7:0] HdrByte1 = 8'h20;
  localparam logic [7:0] MarkByte = 8'h01;
  localparam logic [7:0] ModeLimit = 8'd3;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [1:0]  active_ch;
    logic [47:0] vset;
    logic [47:0] ilim;
    logic [2:0]  en_req;
    logic        ocp_req;
    logic [1:0]  mode_req;
    logic        acq_run;
  } cfg_t;

  typedef struct packed {
    logic [MaxCh-1:0][15:0] volts;
    logic [MaxCh-1:0][15:0] amps;
    logic [MaxCh-1:0]       en;
    logic                   ocp;
    logic [1:0]             mode;
  } stat_t;

  typedef struct packed {
    logic  push;
    stat_t data;
  } q_wr_t;

endpackage

// ===== design/plfe_if.sv =====
// Request and result channels of the supply link frame engine.
// Stands alone; the result channel mirrors the result fields.
interface plfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface plfe_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [15:0] volt_ch0;
  logic [15:0] volt_ch1;
  logic [15:0] volt_ch2;
  logic [15:0] amp_ch0;
  logic [15:0] amp_ch1;
  logic [15:0] amp_ch2;
  logic [2:0]  enabled_mask;
  logic        ocp_on;
  logic [1:0]  chan_mode;

  modport source (output valid, output kind, output tx_byte, output last,
                  output volt_ch0, output volt_ch1, output volt_ch2,
                  output amp_ch0, output amp_ch1, output amp_ch2,
                  output enabled_mask, output ocp_on, output chan_mode,
                  input ready);
  modport sink   (input valid, input kind, input tx_byte, input last,
                  input volt_ch0, input volt_ch1, input volt_ch2,
                  input amp_ch0, input amp_ch1, input amp_ch2,
                  input enabled_mask, input ocp_on, input chan_mode,
                  output ready);
endinterface

// ===== design/psu_link_frame_engine_unit.sv =====
// Supply link frame engine: one received byte per cycle in, one result per cycle out while out_o is ready.
// The byte that completes a frame has its status pushed into the queue, then registered at the output.
// With acquisition running a frame yields 1 + FRAME_BYTES results; input stalls on a full queue.
// Reset clears the byte counter, the kept status, the queue and the config registers
// (active channels 3, all others 0); no clearing pass is needed.
module psu_link_frame_engine_unit #(
  parameter int unsigned FRAME_BYTES = 24,
  parameter int unsigned CHANNELS    = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  plfe_in_if.sink                       in_i,
  plfe_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [plfe_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [plfe_pkg::CfgDataW-1:0] cfg_wdata_i
);

  plfe_pkg::cfg_t  cfg_q;
  plfe_pkg::q_wr_t q_wr;
  plfe_pkg::stat_t q_data;
  logic            q_full, q_empty, q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{active_ch: 2'd3, default: '0};
    end else if (cfg_we_i) begin
      unique case (plfe_pkg::cfg_reg_e'(cfg_idx_i))
        plfe_pkg::REG_ACTIVE_CH: cfg_q.active_ch <= cfg_wdata_i[1:0];
        plfe_pkg::REG_VSET:      cfg_q.vset      <= cfg_wdata_i[47:0];
        plfe_pkg::REG_ILIM:      cfg_q.ilim      <= cfg_wdata_i[47:0];
        plfe_pkg::REG_EN_REQ:    cfg_q.en_req    <= cfg_wdata_i[2:0];
        plfe_pkg::REG_OCP_REQ:   cfg_q.ocp_req   <= cfg_wdata_i[0];
        plfe_pkg::REG_MODE_REQ:  cfg_q.mode_req  <= cfg_wdata_i[1:0];
        plfe_pkg::REG_ACQ_RUN:   cfg_q.acq_run   <= cfg_wdata_i[0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  plfe_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .CHANNELS    (CHANNELS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .active_ch_i (cfg_q.active_ch),
    .full_i      (q_full),
    .q_wr_o      (q_wr)
  );

  plfe_queue #(
    .DEPTH (plfe_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_wr_i  (q_wr),
    .pop_i   (q_pop),
    .data_o  (q_data),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  plfe_back #(
    .FRAME_BYTES (FRAME_BYTES),
    .CHANNELS    (CHANNELS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_data_i  (q_data),
    .q_empty_i (q_empty),
    .pop_o     (q_pop),
    .out_o     (out_o)
  );

endmodule

// ===== design/plfe_front.sv =====
// Front end: collects received bytes into a frame and decodes channel status.
// Depends on plfe_pkg and plfe_in_if; pushes decoded status into the queue.
module plfe_front #(
  parameter int unsigned FRAME_BYTES = 24,
  parameter int unsigned CHANNELS    = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  plfe_in_if.sink           in_i,
  input  logic [1:0]        active_ch_i,
  input  logic              full_i,
  output plfe_pkg::q_wr_t   q_wr_o
);

  localparam int unsigned CntW    = $clog2(FRAME_BYTES);
  localparam int unsigned LastPos = FRAME_BYTES - 1;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            at_last;
  logic            accept;

  logic [CHANNELS-1:0][3:0][7:0] cap_q;
  logic [plfe_pkg::MaxCh-1:0]    cap_en_q;
  logic                          cap_ocp_q;
  logic                          cap_mode_ok_q;
  logic [1:0]                    cap_mode_q;

  plfe_pkg::stat_t stat_q, stat_d;

  assign at_last    = (cnt_q == CntW'(LastPos));
  assign in_i.ready = !full_i || !at_last;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = at_last ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      stat_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept && at_last) begin
        stat_q <= stat_d;
      end
    end
  end

  // Capture only the bytes that the decode reads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        for (int b = 0; b < 4; b++) begin
          if (cnt_q == CntW'(plfe_pkg::PosChBase + 4 * ch + b)) begin
            cap_q[ch][b] <= in_i.rx_byte;
          end
        end
      end
      if (cnt_q == CntW'(plfe_pkg::PosEn)) begin
        cap_en_q <= in_i.rx_byte[plfe_pkg::MaxCh-1:0];
      end
      if (cnt_q == CntW'(plfe_pkg::PosOcp)) begin
        cap_ocp_q <= (in_i.rx_byte != 8'd0);
      end
      if (cnt_q == CntW'(plfe_pkg::PosMode)) begin
        cap_mode_ok_q <= (in_i.rx_byte < plfe_pkg::ModeLimit);
        cap_mode_q    <= in_i.rx_byte[1:0];
      end
    end
  end

  // Inactive channels keep their last reported values
  always_comb begin
    stat_d = stat_q;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (2'(ch) < active_ch_i) begin
        stat_d.volts[ch] = {cap_q[ch][0], cap_q[ch][1]};
        stat_d.amps[ch]  = {cap_q[ch][2], cap_q[ch][3]};
        stat_d.en[ch]    = cap_en_q[ch];
      end
    end
    stat_d.ocp = cap_ocp_q;
    if (cap_mode_ok_q) begin
      stat_d.mode = cap_mode_q;
    end
  end

  assign q_wr_o.push = accept && at_last;
  assign q_wr_o.data = stat_d;

endmodule

// ===== design/plfe_queue.sv =====
// Short queue of decoded status between the front and the back end.
// Depends on plfe_pkg.
module plfe_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plfe_pkg::q_wr_t   q_wr_i,
  input  logic              pop_i,
  output plfe_pkg::stat_t   data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  plfe_pkg::stat_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push, pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign push    = q_wr_i.push;
  assign pop     = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= q_wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_wr_i.push |-> !full_o || pop_i)
    else $error("status pushed into a full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count out of range");

endmodule

// ===== design/plfe_back.sv =====
// Back end: emits the status result and, if acq_run is set, the setting frame, one per cycle unless stalled.
// Depends on plfe_pkg and plfe_out_if; takes decoded status from the queue.
module plfe_back #(
  parameter int unsigned FRAME_BYTES = 24,
  parameter int unsigned CHANNELS    = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  plfe_pkg::cfg_t    cfg_i,
  input  plfe_pkg::stat_t   q_data_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  plfe_out_if.source        out_o
);

  localparam int unsigned IdxW    = $clog2(FRAME_BYTES);
  localparam int unsigned LastPos = FRAME_BYTES - 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_TX   = 2'b10
  } bstate_e;

  bstate_e         state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      sum_q, sum_d;

  logic            valid_q, valid_d;
  plfe_pkg::kind_e kind_q, kind_d;
  logic [7:0]      tx_q, tx_d;
  logic            last_q, last_d;
  plfe_pkg::stat_t stat_q, stat_d;

  logic            adv;
  logic            idx_last;
  logic [7:0]      set_byte;
  logic [2:0]      en_mask;

  assign adv      = !valid_q || out_o.ready;
  assign idx_last = (idx_q == IdxW'(LastPos));

  always_comb begin
    en_mask = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      en_mask[ch] = cfg_i.en_req[ch] && (2'(ch) < cfg_i.active_ch);
    end
  end

  // Setting frame byte at the current position, checksum excluded
  always_comb begin
    set_byte = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (2'(ch) < cfg_i.active_ch) begin
        if (idx_q == IdxW'(plfe_pkg::PosChBase + 4 * ch)) begin
          set_byte = cfg_i.vset[16*ch+8 +: 8];
        end
        if (idx_q == IdxW'(plfe_pkg::PosChBase + 4 * ch + 1)) begin
          set_byte = cfg_i.vset[16*ch +: 8];
        end
        if (idx_q == IdxW'(plfe_pkg::PosChBase + 4 * ch + 2)) begin
          set_byte = cfg_i.ilim[16*ch+8 +: 8];
        end
        if (idx_q == IdxW'(plfe_pkg::PosChBase + 4 * ch + 3)) begin
          set_byte = cfg_i.ilim[16*ch +: 8];
        end
      end
    end
    if (idx_q == IdxW'(0)) begin
      set_byte = plfe_pkg::HdrByte0;
    end
    if (idx_q == IdxW'(1)) begin
      set_byte = plfe_pkg::HdrByte1;
    end
    if (idx_q == IdxW'(plfe_pkg::PosMarkA) || idx_q == IdxW'(plfe_pkg::PosMarkB)) begin
      set_byte = plfe_pkg::MarkByte;
    end
    if (idx_q == IdxW'(plfe_pkg::PosEn)) begin
      set_byte = {5'd0, en_mask};
    end
    if (idx_q == IdxW'(plfe_pkg::PosOcp)) begin
      set_byte = {7'd0, cfg_i.ocp_req};
    end
    if (idx_q == IdxW'(plfe_pkg::PosMode)) begin
      set_byte = {6'd0, cfg_i.mode_req};
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    valid_d = valid_q;
    kind_d  = kind_q;
    tx_d    = tx_q;
    last_d  = last_q;
    stat_d  = stat_q;
    pop_o   = 1'b0;
    if (adv) begin
      valid_d = 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!q_empty_i) begin
            pop_o   = 1'b1;
            valid_d = 1'b1;
            kind_d  = plfe_pkg::KIND_STATUS;
            tx_d    = '0;
            last_d  = !cfg_i.acq_run;
            stat_d  = q_data_i;
            if (cfg_i.acq_run) begin
              state_d = ST_TX;
              idx_d   = '0;
              sum_d   = '0;
            end
          end
        end
        ST_TX: begin
          valid_d = 1'b1;
          kind_d  = plfe_pkg::KIND_TX;
          tx_d    = idx_last ? sum_q : set_byte;
          last_d  = idx_last;
          stat_d  = '0;
          sum_d   = sum_q + set_byte;
          idx_d   = idx_q + 1'b1;
          if (idx_last) begin
            state_d = ST_IDLE;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    sum_q  <= sum_d;
    kind_q <= kind_d;
    tx_q   <= tx_d;
    last_q <= last_d;
    stat_q <= stat_d;
  end

  assign out_o.valid        = valid_q;
  assign out_o.kind         = kind_q;
  assign out_o.tx_byte      = tx_q;
  assign out_o.last         = last_q;
  assign out_o.volt_ch0     = stat_q.volts[0];
  assign out_o.volt_ch1     = stat_q.volts[1];
  assign out_o.volt_ch2     = stat_q.volts[2];
  assign out_o.amp_ch0      = stat_q.amps[0];
  assign out_o.amp_ch1      = stat_q.amps[1];
  assign out_o.amp_ch2      = stat_q.amps[2];
  assign out_o.enabled_mask = stat_q.en;
  assign out_o.ocp_on       = stat_q.ocp;
  assign out_o.chan_mode    = stat_q.mode;

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TX && adv && idx_last) |=>
      (state_q == ST_IDLE && valid_q && last_q && kind_q == plfe_pkg::KIND_TX))
    else $error("setting frame did not close on its checksum byte");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q && kind_q == plfe_pkg::KIND_STATUS)
    else $error("popped status not shown as a status result");

endmodule
